// File: src/cus_pkg.sv
`timescale 1ns / 1ps

package cus_pkg;

	// widths of the usage counters and of the random fraction
	localparam int COUNT_WIDTH = 32;
	localparam int RAND_WIDTH  = 32;

	// codon space and synonym lists
	localparam int NCODON    = 64;
	localparam int CODON_W   = 6;
	localparam int MAX_SYN   = 6;
	localparam int SYN_CNT_W = 3;

	// sum of up to six counters, and the chunked multiply that scales it
	localparam int SUM_W   = COUNT_WIDTH + 3;
	localparam int CHUNK_W = 16;
	localparam int NCHUNK  = (SUM_W + CHUNK_W - 1) / CHUNK_W;
	localparam int SUM_PAD = NCHUNK * CHUNK_W;
	localparam int PROD_W  = RAND_WIDTH + SUM_PAD;
	localparam int STEP_W  = $clog2(NCHUNK + 1);

	// standard genetic code, codon 0 in the top byte
	localparam logic [NCODON-1:0][7:0] CODE_TAB =
		"FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_COUNT = 2'd1,
		MODE_SUBST = 2'd2,
		MODE_XLATE = 2'd3
	} cus_mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_BASE = 2'd1,
		STAT_NO_COUNT = 2'd2
	} cus_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT,
		ST_SUM,
		ST_SCALE,
		ST_SEL,
		ST_DONE
	} cus_state_t;

	typedef logic [MAX_SYN-1:0][CODON_W-1:0] cus_syn_list_t;

	typedef struct packed {
		logic [SYN_CNT_W-1:0] n;
		cus_syn_list_t        list;
	} cus_syn_row_t;

	typedef cus_syn_row_t [NCODON-1:0] cus_syn_tab_t;

	// word handed from the front end to the core
	typedef struct packed {
		cus_mode_t              mode;
		logic                   bad;
		logic [CODON_W-1:0]     codon;
		logic [RAND_WIDTH-1:0]  r;
	} cus_req_t;

	// result handed from the core to the output register
	typedef struct packed {
		cus_status_t        status;
		logic [7:0]         aa;
		logic               subst;
		logic [CODON_W-1:0] sel;
	} cus_res_t;

	// amino-acid letter of a codon
	function automatic logic [7:0] code_aa(input logic [CODON_W-1:0] c);
		return CODE_TAB[CODON_W'(NCODON - 1) - c];
	endfunction

	// ascii letter of a 2-bit base code
	function automatic logic [7:0] base_letter(input logic [1:0] c);
		logic [7:0] l;
		case (c)
			2'd0: l = "T";
			2'd1: l = "C";
			2'd2: l = "A";
			default: l = "G";
		endcase
		return l;
	endfunction

	// 2-bit code of an ascii base, msb flags an unknown base
	function automatic logic [2:0] base_code(input logic [7:0] b);
		logic [2:0] c;
		case (b)
			"T": c = 3'b000;
			"C": c = 3'b001;
			"A": c = 3'b010;
			"G": c = 3'b011;
			default: c = 3'b100;
		endcase
		return c;
	endfunction

	// synonym list of every codon in ascending codon order
	function automatic cus_syn_tab_t build_syn_tab();
		cus_syn_tab_t t;
		int n;
		t = '0;
		for (int c = 0; c < NCODON; c++) begin
			n = 0;
			for (int i = 0; i < NCODON; i++) begin
				if (CODE_TAB[NCODON - 1 - i] == CODE_TAB[NCODON - 1 - c] && n < MAX_SYN) begin
					t[c].list[n] = CODON_W'(i);
					n++;
				end
			end
			t[c].n = SYN_CNT_W'(n);
		end
		return t;
	endfunction

	localparam cus_syn_tab_t SYN_TAB = build_syn_tab();

endpackage

// File: src/cus_ram.sv
`timescale 1ns / 1ps

module cus_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/cus_scale.sv
`timescale 1ns / 1ps

module cus_scale import cus_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RAND_WIDTH-1:0] r,
	input  logic [SUM_W-1:0]      sum,
	output logic                  done,
	output logic [SUM_W-1:0]      target
);

	logic                         busy_q;
	logic                         done_q;
	logic [STEP_W-1:0]            step_q;
	logic [RAND_WIDTH-1:0]        r_q;
	logic [SUM_PAD-1:0]           sh_q;
	logic [RAND_WIDTH+CHUNK_W-1:0] pp_q;
	logic [PROD_W-1:0]            acc_q;

	// step counter: one partial product per step, one accumulate behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(NCHUNK)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// r times sum, top chunk of sum first
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= r;
			sh_q  <= SUM_PAD'(sum);
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != STEP_W'(NCHUNK)) begin
				pp_q <= r_q * sh_q[SUM_PAD-1 -: CHUNK_W];
				sh_q <= sh_q << CHUNK_W;
			end
			if (step_q != '0) begin
				acc_q <= (acc_q << CHUNK_W) + PROD_W'(pp_q);
			end
		end
	end

	assign done   = done_q;
	assign target = acc_q[RAND_WIDTH +: SUM_W];

endmodule

// File: src/cus_core.sv
`timescale 1ns / 1ps

module cus_core import cus_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cus_req_t req,
	input  logic     ack,
	output logic     done,
	output cus_res_t res
);

	cus_state_t           state_q, state_d;
	logic [NCODON-1:0]    vld_q;
	logic                 rd_pend_q;
	logic                 rvld_q;
	logic [CODON_W-1:0]   rd_addr_q;
	logic [SYN_CNT_W-1:0] left_q;
	logic                 found_q;
	cus_mode_t            mode_q;
	cus_status_t          status_q;
	logic [7:0]           aa_q;
	logic [CODON_W-1:0]   codon_q;
	logic [RAND_WIDTH-1:0] r_q;
	cus_syn_list_t        row_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     run_q;
	logic [CODON_W-1:0]   sel_q;

	logic                   ram_re;
	logic                   ram_we;
	logic [CODON_W-1:0]     ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [COUNT_WIDTH-1:0] cnt_val;
	logic                   issue;
	logic                   walk_end;
	logic                   scale_start;
	logic                   scale_done;
	logic [SUM_W-1:0]       target;
	logic [SUM_W-1:0]       add_in;
	logic [SUM_W-1:0]       add_out;
	logic                   start_cnt;

	cus_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NCODON)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(codon_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cus_scale u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scale_start),
		.r     (r_q),
		.sum   (sum_q),
		.done  (scale_done),
		.target(target)
	);

	// a counter never written since the last clear reads as zero
	assign cnt_val = rvld_q ? ram_rdata : '0;

	// the shared adder: sum in the first walk, running count in the second
	assign add_in  = (state_q == ST_SEL) ? run_q : sum_q;
	assign add_out = add_in + SUM_W'(cnt_val);

	// saturating increment
	assign ram_wdata = (cnt_val == '1) ? cnt_val : cnt_val + 1'b1;

	assign start_cnt = start && req.mode == MODE_COUNT && !req.bad;
	assign issue     = (state_q == ST_SUM || state_q == ST_SEL) && left_q != '0;
	assign walk_end  = left_q == '0 && !rd_pend_q;

	// next state and controls
	always_comb begin
		state_d     = state_q;
		ram_re      = 1'b0;
		ram_raddr   = row_q[0];
		ram_we      = 1'b0;
		scale_start = 1'b0;
		done        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = req.codon;
				ram_re    = start_cnt;
				if (start) begin
					if (req.mode == MODE_CLEAR || req.bad || req.mode == MODE_XLATE) begin
						state_d = ST_DONE;
					end else if (req.mode == MODE_COUNT) begin
						state_d = ST_CNT;
					end else begin
						state_d = ST_SUM;
					end
				end
			end
			ST_CNT: begin
				ram_we  = 1'b1;
				state_d = ST_DONE;
			end
			ST_SUM: begin
				ram_re = issue;
				if (walk_end) begin
					if (sum_q == '0) begin
						state_d = ST_DONE;
					end else begin
						scale_start = 1'b1;
						state_d     = ST_SCALE;
					end
				end
			end
			ST_SCALE: begin
				if (scale_done) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				ram_re = issue;
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done = 1'b1;
				if (ack) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vld_q     <= '0;
			rd_pend_q <= 1'b0;
			left_q    <= '0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= ram_re;
			if (ram_we) begin
				vld_q[codon_q] <= 1'b1;
			end
			if (state_q == ST_IDLE && start) begin
				if (req.mode == MODE_CLEAR) begin
					vld_q <= '0;
				end
				left_q  <= SYN_TAB[req.codon].n;
				found_q <= 1'b0;
			end else if (issue) begin
				left_q <= left_q - 1'b1;
			end else if (scale_start) begin
				left_q <= SYN_TAB[codon_q].n;
			end
			if (state_q == ST_SEL && rd_pend_q && !found_q && add_out > target) begin
				found_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_q <= ram_raddr;
			rvld_q    <= vld_q[ram_raddr];
		end
		if (state_q == ST_IDLE && start) begin
			mode_q  <= req.mode;
			codon_q <= req.codon;
			r_q     <= req.r;
			row_q   <= SYN_TAB[req.codon].list;
			sum_q   <= '0;
			run_q   <= '0;
			if (req.mode == MODE_CLEAR) begin
				status_q <= STAT_OK;
				aa_q     <= '0;
			end else if (req.bad) begin
				status_q <= STAT_BAD_BASE;
				aa_q     <= '0;
			end else begin
				status_q <= STAT_OK;
				aa_q     <= code_aa(req.codon);
			end
		end else begin
			if (issue) begin
				row_q <= cus_syn_list_t'(row_q >> CODON_W);
			end else if (scale_start) begin
				row_q <= SYN_TAB[codon_q].list;
			end
			if (state_q == ST_SUM && rd_pend_q) begin
				sum_q <= add_out;
			end
			if (state_q == ST_SUM && walk_end && sum_q == '0) begin
				status_q <= STAT_NO_COUNT;
			end
			if (state_q == ST_SEL && rd_pend_q) begin
				run_q <= add_out;
				if (!found_q && add_out > target) begin
					sel_q <= rd_addr_q;
				end
			end
		end
	end

	assign res.status = status_q;
	assign res.aa     = aa_q;
	assign res.subst  = found_q;
	assign res.sel    = sel_q;

	// a substitution with a nonzero sum always lands on a codon
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && mode_q == MODE_SUBST && status_q == STAT_OK) |-> found_q)
		else $error("substitution finished without a selected codon");

	// read data is only pending where a walk or an update consumes it
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (state_q == ST_CNT || state_q == ST_SUM || state_q == ST_SEL))
		else $error("counter read pending outside a consuming state");

	// the scaled target stays below the synonym sum
	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL) |-> (target < sum_q))
		else $error("target not below synonym sum");

	// a clear word leaves every counter reading zero
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && req.mode == MODE_CLEAR) |=> (vld_q == '0))
		else $error("counters not cleared");

endmodule

// File: src/codon_usage_synonymous_sampler.sv
`timescale 1ns / 1ps

// channel  direction  handshake           payload
// in       to block   in_valid/in_stall   mode, base_first, base_second, base_third,
//                                         random_fraction
// out      from block out_valid/out_stall out_first, out_second, out_third,
//                                         amino_letter, status
//
// one word at a time: clear, translate and bad bases need no count memory access,
// count does a read, then a write of the count memory, and substitute handles n
// synonyms (up to 6): the shared adder walks the count memory twice, once to sum and
// once to select with a chunked multiply between, or once if the counts sum to zero
// arst_n clears control state and marks all 64 counters as zero at once
// in_stall is high while a word is in work; a pending output word holds under out_stall
// and does not block the next input word

module codon_usage_synonymous_sampler import cus_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [7:0]            base_first,
	input  logic [7:0]            base_second,
	input  logic [7:0]            base_third,
	input  logic [31:0]           random_fraction,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_first,
	output logic [7:0]            out_second,
	output logic [7:0]            out_third,
	output logic [7:0]            amino_letter,
	output logic [1:0]            status
);

	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] b1_q, b2_q, b3_q;
	logic [7:0] out_first_q, out_second_q, out_third_q, amino_q;
	logic [1:0] status_q;

	logic       accept;
	logic       load;
	logic       core_done;
	logic [2:0] c1, c2, c3;
	cus_req_t   req;
	cus_res_t   res;

	// base decode into a codon number
	always_comb begin
		c1        = base_code(base_first);
		c2        = base_code(base_second);
		c3        = base_code(base_third);
		req.mode  = cus_mode_t'(mode);
		req.bad   = c1[2] | c2[2] | c3[2];
		req.codon = {c1[1:0], c2[1:0], c3[1:0]};
		req.r     = random_fraction[RAND_WIDTH-1:0];
	end

	assign accept = in_valid && !in_stall;
	assign load   = core_done && (!out_valid_q || !out_stall);

	cus_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.req   (req),
		.ack   (load),
		.done  (core_done),
		.res   (res)
	);

	// handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// echo bases and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			b1_q <= base_first;
			b2_q <= base_second;
			b3_q <= base_third;
		end
		if (load) begin
			out_first_q  <= res.subst ? base_letter(res.sel[5:4]) : b1_q;
			out_second_q <= res.subst ? base_letter(res.sel[3:2]) : b2_q;
			out_third_q  <= res.subst ? base_letter(res.sel[1:0]) : b3_q;
			amino_q      <= res.aa;
			status_q     <= res.status;
		end
	end

	assign in_stall     = busy_q;
	assign out_valid    = out_valid_q;
	assign out_first    = out_first_q;
	assign out_second   = out_second_q;
	assign out_third    = out_third_q;
	assign amino_letter = amino_q;
	assign status       = status_q;

endmodule
